/* rtl/ipv4_udp_header_builder_macros.svh */
// Assertion macros shared by the header builder checker.
// Depends on a clk and an active-low rst_n in the scope where they are used.
`ifndef IPV4_UDP_HEADER_BUILDER_MACROS_SVH
`define IPV4_UDP_HEADER_BUILDER_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define IHB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("header builder check failed");

// Checks that cons holds in the cycle after ante.
`define IHB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("header builder check failed");

`endif

/* rtl/ihb_pkg.sv */
// Types and constants of the IPv4/UDP header builder.
// Used by every module of the block; depends on nothing.
package ihb_pkg;

    localparam logic [1:0] MODE_TRANSIENT = 2'd0;
    localparam logic [1:0] MODE_SUBBANDS  = 2'd1;

    typedef enum logic [1:0] {
        CFG_BASE_PORT = 2'd0,
        CFG_TRANSIENT = 2'd1,
        CFG_SUBBAND   = 2'd2
    } ihb_cfg_idx_t;

    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [7:0]  IP_TOS        = 8'h00;
    localparam logic [15:0] IP_IDENT      = 16'h0000;
    localparam logic [15:0] IP_FLAGS_DF   = 16'h4000;
    localparam logic [7:0]  IP_TTL        = 8'd128;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
    localparam logic [15:0] IP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [15:0] UDP_CSUM      = 16'h0000;

    // Sum of the header halves that never change (checksum field taken as zero).
    localparam logic [17:0] CSUM_FIXED = {2'b00, IP_VER_IHL, IP_TOS}
                                       + {2'b00, IP_IDENT}
                                       + {2'b00, IP_FLAGS_DF}
                                       + {2'b00, IP_TTL, IP_PROTO_UDP};

    typedef struct packed {
        logic [15:0] base_port;
        logic [15:0] transient_bytes;
        logic [15:0] subband_bytes;
    } ihb_cfg_t;

    typedef struct packed {
        logic [15:0] port;
        logic [15:0] total_len;
        logic [15:0] udp_len;
        logic [31:0] src;
        logic [31:0] dst;
    } ihb_hdr_t;

    typedef struct packed {
        logic     valid;
        ihb_hdr_t hdr;
    } ihb_s1_t;

    typedef struct packed {
        logic        valid;
        ihb_hdr_t    hdr;
        logic [17:0] sum_a;
        logic [17:0] sum_b;
    } ihb_s2_t;

    typedef struct packed {
        logic        valid;
        ihb_hdr_t    hdr;
        logic [16:0] fold;
    } ihb_s3_t;

endpackage

/* rtl/ihb_cfg.sv */
// Configuration registers of the header builder.
// Depends on ihb_pkg.
module ihb_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output ihb_pkg::ihb_cfg_t cfg
);
    import ihb_pkg::*;

    ihb_cfg_t cfg_reg;
    ihb_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_PORT: cfg_next.base_port       = cfg_data;
                CFG_TRANSIENT: cfg_next.transient_bytes = cfg_data;
                CFG_SUBBAND:   cfg_next.subband_bytes   = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/ihb_len_stage.sv */
// First pipeline stage: payload size by mode, IP and UDP lengths, UDP port.
// Depends on ihb_pkg.
module ihb_len_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  ihb_pkg::ihb_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       board_number,
    input  logic [1:0]        frame_mode,
    input  logic [31:0]       source_address,
    input  logic [31:0]       dest_address,
    input  logic              out_ready,
    output ihb_pkg::ihb_s1_t  out
);
    import ihb_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    ihb_hdr_t    hdr_reg;
    ihb_hdr_t    hdr_next;
    logic [15:0] payload;

    always_comb
    begin
        case (frame_mode)
            MODE_TRANSIENT: payload = cfg.transient_bytes;
            MODE_SUBBANDS:  payload = cfg.subband_bytes;
            default:        payload = 16'd0;
        endcase
    end

    // Lengths and port wrap at 16 bits.
    always_comb
    begin
        hdr_next.port      = cfg.base_port + board_number;
        hdr_next.total_len = IP_HDR_BYTES + UDP_HDR_BYTES + payload;
        hdr_next.udp_len   = UDP_HDR_BYTES + payload;
        hdr_next.src       = source_address;
        hdr_next.dst       = dest_address;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            hdr_reg <= hdr_next;
    end

    assign out.valid = valid_reg;
    assign out.hdr   = hdr_reg;

endmodule

/* rtl/ihb_csum_stage.sv */
// Second and third pipeline stages: header checksum partial sums and first fold.
// Depends on ihb_pkg.
module ihb_csum_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  ihb_pkg::ihb_s1_t in,
    output logic             in_ready,
    input  logic             out_ready,
    output ihb_pkg::ihb_s3_t out
);
    import ihb_pkg::*;

    ihb_s2_t     s2_reg;
    ihb_s2_t     s2_next;
    ihb_s3_t     s3_reg;
    ihb_s3_t     s3_next;
    logic        s2_ready;
    logic        s3_ready;
    logic [18:0] sum;

    assign s3_ready = !s3_reg.valid || out_ready;
    assign s2_ready = !s2_reg.valid || s3_ready;
    assign in_ready = s2_ready;

    // Split the ten halves over two adders; the fixed halves ride in sum_b.
    always_comb
    begin
        s2_next.valid = in.valid;
        s2_next.hdr   = in.hdr;
        s2_next.sum_a = {2'b00, in.hdr.total_len} + {2'b00, in.hdr.src[31:16]}
                      + {2'b00, in.hdr.src[15:0]};
        s2_next.sum_b = {2'b00, in.hdr.dst[31:16]} + {2'b00, in.hdr.dst[15:0]}
                      + CSUM_FIXED;
    end

    always_comb
    begin
        sum           = {1'b0, s2_reg.sum_a} + {1'b0, s2_reg.sum_b};
        s3_next.valid = s2_reg.valid;
        s3_next.hdr   = s2_reg.hdr;
        s3_next.fold  = {1'b0, sum[15:0]} + {14'd0, sum[18:16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            if (s2_ready)
                s2_reg.valid <= s2_next.valid;
            if (s3_ready)
                s3_reg.valid <= s3_next.valid;
            if (s2_ready && s2_next.valid)
            begin
                s2_reg.hdr   <= s2_next.hdr;
                s2_reg.sum_a <= s2_next.sum_a;
                s2_reg.sum_b <= s2_next.sum_b;
            end
            if (s3_ready && s3_next.valid)
            begin
                s3_reg.hdr  <= s3_next.hdr;
                s3_reg.fold <= s3_next.fold;
            end
        end
    end

    assign out = s3_reg;

endmodule

/* rtl/ipv4_udp_header_builder.sv */
// IPv4/UDP header builder: a four-stage pipeline from request to header words.
// Depends on ihb_pkg, ihb_cfg, ihb_len_stage and ihb_csum_stage.
//
// Usage: a request carries board_number, frame_mode and the source and
// destination addresses on in_valid/in_stall. Each request yields exactly one
// result on out_valid/out_stall: the five IPv4 header words and two UDP words.
// Registers are written through cfg_we/cfg_index/cfg_data only while no
// request is in flight; the user must keep to this, as the block does not
// enforce it. Indexes beyond the register list are ignored. A request passes
// the length stage, two checksum stages and the output register before its
// result appears on the outputs. Throughput is one request per cycle unless
// the receiver stalls; each stage holds one request with its own valid bit.
// When the receiver stalls, the output register holds its result and each
// stage keeps filling until the one behind it is full, then in_stall rises.
// Nothing is dropped or repeated. Reset clears all valid bits and sets the
// registers to zero.
module ipv4_udp_header_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] board_number,
    input  logic [1:0]  frame_mode,
    input  logic [31:0] source_address,
    input  logic [31:0] dest_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] ip_word0,
    output logic [31:0] ip_word1,
    output logic [31:0] ip_word2,
    output logic [31:0] ip_word3,
    output logic [31:0] ip_word4,
    output logic [31:0] udp_word0,
    output logic [31:0] udp_word1
);
    import ihb_pkg::*;

    ihb_cfg_t    cfg;
    ihb_s1_t     s1;
    ihb_s3_t     s3;
    logic        s1_in_ready;
    logic        s2_in_ready;
    logic        out_ready;
    logic        out_valid_reg;
    logic        out_valid_next;
    ihb_hdr_t    hdr_reg;
    logic [15:0] csum_reg;
    logic [15:0] csum_next;

    ihb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ihb_len_stage u_len (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_ready       (s1_in_ready),
        .board_number   (board_number),
        .frame_mode     (frame_mode),
        .source_address (source_address),
        .dest_address   (dest_address),
        .out_ready      (s2_in_ready),
        .out            (s1)
    );

    ihb_csum_stage u_csum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (s1),
        .in_ready  (s2_in_ready),
        .out_ready (out_ready),
        .out       (s3)
    );

    assign in_stall = !s1_in_ready;

    // The first fold leaves at most one more carry; fold it and invert.
    assign csum_next = ~(s3.fold[15:0] + {15'd0, s3.fold[16]});

    assign out_ready      = !out_valid_reg || !out_stall;
    assign out_valid_next = out_ready ? s3.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s3.valid)
        begin
            hdr_reg  <= s3.hdr;
            csum_reg <= csum_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ip_word0  = {IP_VER_IHL, IP_TOS, hdr_reg.total_len};
    assign ip_word1  = {IP_IDENT, IP_FLAGS_DF};
    assign ip_word2  = {IP_TTL, IP_PROTO_UDP, csum_reg};
    assign ip_word3  = hdr_reg.src;
    assign ip_word4  = hdr_reg.dst;
    assign udp_word0 = {hdr_reg.port, hdr_reg.port};
    assign udp_word1 = {hdr_reg.udp_len, UDP_CSUM};

endmodule

/* rtl/ihb_checker.sv */
// Port-level checker for the IPv4/UDP header builder, bound to the top level.
// Depends on ipv4_udp_header_builder_macros.svh.
`include "ipv4_udp_header_builder_macros.svh"

module ihb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] ip_word0,
    input logic [31:0] ip_word1,
    input logic [31:0] ip_word2,
    input logic [31:0] udp_word0,
    input logic [31:0] udp_word1
);

    logic fixed_ok;

    assign fixed_ok = (ip_word0[31:16] == 16'h4500) && (ip_word1 == 32'h0000_4000)
                   && (ip_word2[31:16] == 16'h8011) && (udp_word1[15:0] == 16'h0000);

    // Fixed header fields never change, whatever the request.
    `IHB_ASSERT_SAME(a_fixed_fields, out_valid, fixed_ok)

    // Both UDP ports come from the same sum.
    `IHB_ASSERT_SAME(a_ports_equal, out_valid, udp_word0[31:16] == udp_word0[15:0])

    // The IP total length is the UDP length plus the IP header, modulo 2^16.
    `IHB_ASSERT_SAME(a_len_match, out_valid, ip_word0[15:0] == (udp_word1[31:16] + 16'd20))

    // A stalled result stays in place with its checksum.
    `IHB_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(ip_word2) && $stable(udp_word0))

endmodule

bind ipv4_udp_header_builder ihb_checker u_ihb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ip_word0  (ip_word0),
    .ip_word1  (ip_word1),
    .ip_word2  (ip_word2),
    .udp_word0 (udp_word0),
    .udp_word1 (udp_word1)
);
